### hw/rtl/imhrk_pkg.sv
package imhrk_pkg;

  typedef enum logic [2:0] {
    REQ_INSERT   = 3'd0,
    REQ_DECREASE = 3'd1,
    REQ_INCREASE = 3'd2,
    REQ_POP      = 3'd3,
    REQ_REMOVE   = 3'd4,
    REQ_PEEK     = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_PRESENT = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_DECIDE,
    S_UP_RD, S_UP_WAIT, S_UP_MUL, S_UP_CMP,
    S_DN_RD, S_DN_WAIT, S_DN_MUL1, S_DN_CMP1, S_DN_MUL2, S_DN_CMP2,
    S_POP_RD, S_POP_WAIT, S_POP_WR,
    S_TOP_RD, S_TOP_WAIT, S_OUT
  } state_t;

  // datapath commands
  typedef enum logic [3:0] {
    C_NONE, C_CLEAR, C_CAPTURE, C_LOOKUP, C_PLACE,
    C_UP_READ, C_UP_MUL, C_UP_SWAP,
    C_DN_READ, C_DN_MUL1, C_DN_PICK, C_DN_MUL2, C_DN_SWAP,
    C_POP_READ, C_POP_MOVE, C_TOP_READ
  } cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic       v_ok;
    logic       present;
    logic       full;
    logic       empty;
    logic       at_root;
    logic       has_child;
    logic       less;
  } stat_t;

  // signed 64-bit cross products
  function automatic logic signed [63:0] mul_nd(logic signed [31:0] n, logic [30:0] d);
    logic signed [63:0] n_ext;
    logic signed [63:0] d_ext;
    n_ext = 64'(n);
    d_ext = $signed({33'd0, d});
    mul_nd = n_ext * d_ext;
  endfunction

endpackage

### hw/rtl/imhrk_if.sv
interface imhrk_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/imhrk_ram.sv
module imhrk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/imhrk_ctrl.sv
module imhrk_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  imhrk_pkg::req_t req,
  input  imhrk_pkg::stat_t st,
  output imhrk_pkg::cmd_t cmd,
  output logic            set_status,
  output imhrk_pkg::status_t status_code
);
  import imhrk_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (st.clear_done) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_LOOK;
      S_LOOK:   state_next = S_DECIDE;
      S_DECIDE: begin
        unique case (req)
          REQ_INSERT:
            state_next = (!st.v_ok || st.present || st.full) ? S_TOP_RD : S_UP_RD;
          REQ_DECREASE, REQ_REMOVE:
            state_next = (!st.v_ok || !st.present) ? S_TOP_RD : S_UP_RD;
          REQ_INCREASE:
            state_next = (!st.v_ok || !st.present) ? S_TOP_RD : S_DN_RD;
          REQ_POP:  state_next = st.empty ? S_TOP_RD : S_POP_RD;
          default:  state_next = S_TOP_RD;
        endcase
      end
      S_UP_RD:   state_next = st.at_root ? ((req == REQ_REMOVE) ? S_POP_RD : S_TOP_RD)
                                         : S_UP_WAIT;
      S_UP_WAIT: state_next = S_UP_MUL;
      S_UP_MUL:  state_next = S_UP_CMP;
      S_UP_CMP:  state_next = (req == REQ_REMOVE || st.less) ? S_UP_RD : S_TOP_RD;
      S_DN_RD:   state_next = st.has_child ? S_DN_WAIT : S_TOP_RD;
      S_DN_WAIT: state_next = S_DN_MUL1;
      S_DN_MUL1: state_next = S_DN_CMP1;
      S_DN_CMP1: state_next = S_DN_MUL2;
      S_DN_MUL2: state_next = S_DN_CMP2;
      S_DN_CMP2: state_next = st.less ? S_DN_RD : S_TOP_RD;
      S_POP_RD:  state_next = S_POP_WAIT;
      S_POP_WAIT: state_next = S_POP_WR;
      S_POP_WR:  state_next = S_DN_RD;
      S_TOP_RD:  state_next = S_TOP_WAIT;
      S_TOP_WAIT: state_next = S_OUT;
      S_OUT:     if (out_ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs; read addresses are held until the data is used
  always_comb begin
    cmd = C_NONE;
    in_ready = 1'b0;
    out_valid = 1'b0;
    set_status = 1'b0;
    status_code = ST_OK;
    unique case (state)
      S_CLEAR: cmd = C_CLEAR;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = C_CAPTURE;
      end
      S_LOOK: cmd = C_LOOKUP;
      S_DECIDE: begin
        set_status = 1'b1;
        unique case (req)
          REQ_INSERT: begin
            if (!st.v_ok) status_code = ST_ABSENT;
            else if (st.present) status_code = ST_PRESENT;
            else if (st.full) status_code = ST_FULL;
            else cmd = C_PLACE;
          end
          REQ_DECREASE, REQ_INCREASE, REQ_REMOVE: begin
            if (!st.v_ok || !st.present) status_code = ST_ABSENT;
            else cmd = C_PLACE;
          end
          REQ_POP: if (st.empty) status_code = ST_EMPTY;
          default: ;
        endcase
      end
      S_UP_RD:   cmd = C_UP_READ;
      S_UP_WAIT: cmd = C_UP_READ;
      S_UP_MUL:  cmd = C_UP_MUL;
      S_UP_CMP:  if (req == REQ_REMOVE || st.less) cmd = C_UP_SWAP;
      S_DN_RD:   cmd = C_DN_READ;
      S_DN_WAIT: cmd = C_DN_READ;
      S_DN_MUL1: cmd = C_DN_MUL1;
      S_DN_CMP1: cmd = C_DN_PICK;
      S_DN_MUL2: cmd = C_DN_MUL2;
      S_DN_CMP2: if (st.less) cmd = C_DN_SWAP;
      S_POP_RD:  cmd = C_POP_READ;
      S_POP_WAIT: cmd = C_POP_READ;
      S_POP_WR:  cmd = C_POP_MOVE;
      S_TOP_RD:  cmd = C_TOP_READ;
      S_TOP_WAIT: cmd = C_TOP_READ;
      S_OUT: begin
        cmd = C_TOP_READ;
        out_valid = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

### hw/rtl/imhrk_dp.sv
module imhrk_dp #(
  parameter int HEAP_SLOTS = 1024,
  parameter int VERTEX_COUNT = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  imhrk_pkg::cmd_t            cmd,
  input  logic                       set_status,
  input  imhrk_pkg::status_t         status_code,
  input  logic [2:0]                 in_req,
  input  logic signed [31:0]         in_num,
  input  logic [30:0]                in_den,
  input  logic [11:0]                in_vertex,
  output imhrk_pkg::req_t            req,
  output imhrk_pkg::stat_t           st,
  output logic signed [31:0]         top_num,
  output logic [30:0]                top_den,
  output logic [11:0]                top_vertex,
  output logic                       heap_empty,
  output logic [9:0]                 entry_count,
  output logic [2:0]                 status
);
  import imhrk_pkg::*;

  localparam int SW = $clog2(HEAP_SLOTS);
  localparam int VW = $clog2(VERTEX_COUNT);
  localparam int EW = 32 + 31 + 12;
  localparam int PW = SW + 1;   // slot plus present bit

  // heap memory, one packed entry per slot; two copies give two read ports
  logic          ha_we;
  logic [SW-1:0] ha_wa, hb_wa, ha_ra, hb_ra;
  logic [EW-1:0] ha_wd, hb_wd, ha_rd, hb_rd;
  logic          hb_we;
  // two writes needed for a swap: the second is deferred via swap2, and both copies take every write
  logic [VW-1:0] pm_wa, pm_ra;
  logic [PW-1:0] pm_wd, pm_rd;
  logic          pm_we;

  // registers
  req_t               r_req;
  logic signed [31:0] r_num;
  logic [30:0]        r_den;
  logic [11:0]        r_vtx;
  logic [SW-1:0]      cnt;
  logic [SW-1:0]      pos;
  logic [VW:0]        clr;
  logic [EW-1:0]      e_cur, e_par, e_l, e_r, e_ch;
  logic [SW-1:0]      ch_idx;
  logic signed [63:0] pa, pb;
  logic               less_r, popped;
  logic [EW-1:0]      popped_e;
  status_t            stat_r;
  logic               pres_r;
  logic [SW-1:0]      pos_r;
  logic               swap2;
  logic [SW-1:0]      sw_a2;
  logic [EW-1:0]      sw_d2;
  logic [VW-1:0]      pm_a2;
  logic [PW-1:0]      pm_d2;

  imhrk_ram #(.WIDTH(EW), .DEPTH(HEAP_SLOTS)) u_heap_a (
    .clk, .we(ha_we), .waddr(ha_wa), .wdata(ha_wd), .raddr(ha_ra), .rdata(ha_rd));
  imhrk_ram #(.WIDTH(EW), .DEPTH(HEAP_SLOTS)) u_heap_b (
    .clk, .we(hb_we), .waddr(hb_wa), .wdata(hb_wd), .raddr(hb_ra), .rdata(hb_rd));
  imhrk_ram #(.WIDTH(PW), .DEPTH(VERTEX_COUNT)) u_pos (
    .clk, .we(pm_we), .waddr(pm_wa), .wdata(pm_wd), .raddr(pm_ra), .rdata(pm_rd));

  function automatic logic signed [31:0] e_num(logic [EW-1:0] e);
    e_num = e[EW-1 -: 32];
  endfunction
  function automatic logic [30:0] e_den(logic [EW-1:0] e);
    e_den = e[42:12];
  endfunction
  function automatic logic [11:0] e_vtx(logic [EW-1:0] e);
    e_vtx = e[11:0];
  endfunction
  function automatic logic [VW-1:0] vidx(logic [11:0] v);
    vidx = VW'(v);
  endfunction

  logic [SW:0] ch_l, ch_r;
  assign ch_l = {pos, 1'b0};
  assign ch_r = {pos, 1'b1};

  // memory access steering
  always_comb begin
    ha_we = 1'b0; hb_we = 1'b0; pm_we = 1'b0;
    ha_wa = '0; ha_wd = '0; pm_wa = '0; pm_wd = '0;
    ha_ra = '0; hb_ra = '0; pm_ra = vidx(r_vtx);
    unique case (cmd)
      C_CLEAR: begin
        pm_we = 1'b1; pm_wa = clr[VW-1:0]; pm_wd = '0;
      end
      // look up the arriving vertex so its slot is ready when C_LOOKUP captures it
      C_CAPTURE: pm_ra = vidx(in_vertex);
      C_PLACE: begin
        ha_we = 1'b1;
        ha_wa = (r_req == REQ_INSERT) ? cnt + 1'b1 : pos_r;
        ha_wd = (r_req == REQ_REMOVE) ? {-32'sd1, 31'd1, r_vtx} : {r_num, r_den, r_vtx};
        pm_we = (r_req == REQ_INSERT);
        pm_wa = vidx(r_vtx);
        pm_wd = {1'b1, SW'(cnt + 1'b1)};
      end
      C_UP_READ: begin ha_ra = pos; hb_ra = pos >> 1; end
      C_DN_READ: begin ha_ra = SW'(ch_l); hb_ra = SW'(ch_r); end
      C_UP_SWAP: begin
        ha_we = 1'b1; ha_wa = pos >> 1; ha_wd = e_cur;
        pm_we = 1'b1; pm_wa = vidx(e_vtx(e_cur)); pm_wd = {1'b1, pos >> 1};
      end
      C_DN_SWAP: begin
        ha_we = 1'b1; ha_wa = ch_idx; ha_wd = e_cur;
        pm_we = 1'b1; pm_wa = vidx(e_vtx(e_cur)); pm_wd = {1'b1, ch_idx};
      end
      C_POP_READ: begin ha_ra = SW'(1); hb_ra = cnt; end
      C_POP_MOVE: begin
        ha_we = 1'b1; ha_wa = SW'(1); ha_wd = hb_rd;
        pm_we = 1'b1; pm_wa = vidx(e_vtx(ha_rd)); pm_wd = '0;
      end
      C_TOP_READ: ha_ra = SW'(1);
      default: ;
    endcase
    // deferred second write of a swap or of a pop's relink
    if (swap2) begin
      ha_we = 1'b1; ha_wa = sw_a2; ha_wd = sw_d2;
      pm_we = 1'b1; pm_wa = pm_a2; pm_wd = pm_d2;
    end
    hb_wa = ha_wa; hb_wd = ha_wd; hb_we = ha_we;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
      cnt <= '0;
      swap2 <= 1'b0;
      popped <= 1'b0;
    end else begin
      swap2 <= 1'b0;
      unique case (cmd)
        C_CLEAR: clr <= clr + 1'b1;
        C_CAPTURE: begin
          r_req <= req_t'(in_req);
          r_num <= in_num; r_den <= in_den; r_vtx <= in_vertex;
          popped <= 1'b0;
          stat_r <= ST_OK;
        end
        C_LOOKUP: ;
        C_PLACE: begin
          if (r_req == REQ_INSERT) begin
            cnt <= cnt + 1'b1; pos <= cnt + 1'b1;
          end else pos <= pos_r;
          e_cur <= (r_req == REQ_REMOVE) ? {-32'sd1, 31'd1, r_vtx} : {r_num, r_den, r_vtx};
        end
        C_UP_MUL: begin
          e_par <= hb_rd;
          pa <= mul_nd(e_num(e_cur), e_den(hb_rd));
          pb <= mul_nd(e_num(hb_rd), e_den(e_cur));
        end
        C_UP_SWAP: begin
          // parent moves down to pos
          swap2 <= 1'b1; sw_a2 <= pos; sw_d2 <= e_par;
          pm_a2 <= vidx(e_vtx(e_par)); pm_d2 <= {1'b1, pos};
          pos <= pos >> 1;
        end
        C_DN_MUL1: begin
          e_l <= ha_rd; e_r <= hb_rd;
          pa <= mul_nd(e_num(hb_rd), e_den(ha_rd));
          pb <= mul_nd(e_num(ha_rd), e_den(hb_rd));
        end
        C_DN_PICK: begin
          if (ch_r <= {1'b0, cnt} && pa < pb) begin
            e_ch <= e_r; ch_idx <= SW'(ch_r);
          end else begin
            e_ch <= e_l; ch_idx <= SW'(ch_l);
          end
        end
        C_DN_MUL2: begin
          pa <= mul_nd(e_num(e_ch), e_den(e_cur));
          pb <= mul_nd(e_num(e_cur), e_den(e_ch));
        end
        C_DN_SWAP: begin
          swap2 <= 1'b1; sw_a2 <= pos; sw_d2 <= e_ch;
          pm_a2 <= vidx(e_vtx(e_ch)); pm_d2 <= {1'b1, pos};
          pos <= ch_idx;
        end
        C_POP_MOVE: begin
          popped <= 1'b1;
          popped_e <= ha_rd;
          e_cur <= hb_rd;
          pos <= SW'(1);
          cnt <= cnt - 1'b1;
          // relink the moved entry (skipped if it was the popped one)
          if (cnt != SW'(1)) begin
            swap2 <= 1'b1; sw_a2 <= SW'(1); sw_d2 <= hb_rd;
            pm_a2 <= vidx(e_vtx(hb_rd)); pm_d2 <= {1'b1, SW'(1)};
          end
        end
        default: ;
      endcase
      if (cmd == C_LOOKUP) begin
        pres_r <= pm_rd[PW-1];
        pos_r <= pm_rd[SW-1:0];
      end
      if (set_status) stat_r <= status_code;
    end
  end

  assign less_r = (pa < pb);
  assign req = r_req;

  always_comb begin
    st.clear_done  = (clr == (VW+1)'(VERTEX_COUNT - 1)) ;
    st.v_ok        = ({20'd0, r_vtx} < 32'(VERTEX_COUNT));
    st.present     = pres_r;
    st.full        = (cnt == SW'(HEAP_SLOTS - 1));
    st.empty       = (cnt == '0);
    st.at_root     = (pos <= SW'(1));
    st.has_child   = (ch_l <= {1'b0, cnt});
    st.less        = less_r;
  end

  // result fields
  logic [EW-1:0] shown;
  assign shown = popped ? popped_e : ha_rd;
  assign top_num    = (popped || cnt != '0) ? e_num(shown) : '0;
  assign top_den    = (popped || cnt != '0) ? e_den(shown) : '0;
  assign top_vertex = (popped || cnt != '0) ? e_vtx(shown) : '0;
  assign heap_empty = (cnt == '0);
  assign entry_count = 10'(cnt);
  assign status = stat_r;
endmodule

### hw/rtl/indexed_min_heap_rational_keys.sv
// Indexed binary min-heap keyed by fractions num/den, compared by signed
// cross products. One request at a time; after reset a clearing pass
// empties the position map before the first item is taken. A sift moves
// the entry up or down one level per step (log2 of HEAP_SLOTS levels each
// at most, a removal walks both), and a pop or removal moves the last
// entry to the root before sifting down. Each step waits on the compare
// multiplier pair and the single-write-port slot memory.
module indexed_min_heap_rational_keys #(
  parameter int HEAP_SLOTS = 1024,
  parameter int VERTEX_COUNT = 4096
) (
  input logic clk,
  input logic rst,
  imhrk_if.sink   req_ch,
  imhrk_if.source rsp_ch
);
  import imhrk_pkg::*;

  req_t    req;
  stat_t   st;
  cmd_t    cmd;
  logic    set_status;
  status_t status_code;
  logic signed [31:0] top_num;
  logic [30:0] top_den;
  logic [11:0] top_vertex;
  logic        heap_empty;
  logic [9:0]  entry_count;
  logic [2:0]  status;

  imhrk_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(req_ch.valid), .in_ready(req_ch.ready),
    .out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready),
    .req, .st, .cmd, .set_status, .status_code);

  imhrk_dp #(.HEAP_SLOTS(HEAP_SLOTS), .VERTEX_COUNT(VERTEX_COUNT)) u_dp (
    .clk, .rst, .cmd, .set_status, .status_code,
    .in_req(req_ch.data[77:75]),
    .in_num(req_ch.data[74:43]),
    .in_den(req_ch.data[42:12]),
    .in_vertex(req_ch.data[11:0]),
    .req, .st, .top_num, .top_den, .top_vertex, .heap_empty, .entry_count, .status);

  assign rsp_ch.data = {top_num, top_den, top_vertex, heap_empty, entry_count, status};

`ifndef SYNTHESIS
  // no item accepted while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp_ch.valid |-> !req_ch.ready) else $error("accept during result");
  // result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid) else $error("result dropped");
  // empty flag agrees with count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_ch.valid |-> (heap_empty == (entry_count == 10'd0))) else $error("empty flag");
`endif
endmodule
